// ===== rtl/core/fog_table_entry_generator_defines.svh =====
// assertion macros shared by the fog table entry generator rtl
// used by fog_table_entry_generator.sv; needs clk and arst_n in scope
`ifndef FOG_TABLE_ENTRY_GENERATOR_DEFINES_SVH
`define FOG_TABLE_ENTRY_GENERATOR_DEFINES_SVH

// condition cons must hold in the same cycle as ante
`define FTE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition cons must hold in the cycle after ante
`define FTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fte_pkg.sv =====
// constants, tables and register codes for the fog table entry generator
// no dependencies; imported by fog_table_entry_generator
`timescale 1ns / 1ps
`default_nettype none

package fte_pkg;

	localparam int ENTRIES = 256;
	localparam int LAST    = (ENTRIES > 1) ? ENTRIES - 1 : 1;

	localparam int IDX_W  = 8;
	localparam int D_W    = 17;
	localparam int FIX_W  = 17;
	localparam int DATA_W = 32;

	localparam logic [FIX_W-1:0] FIX_ONE   = 17'd65536;
	localparam logic [31:0]      MIN_SPAN  = 32'd66;
	localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
	localparam logic [37:0]      X_LIMIT   = 38'd1114112;

	// fog modes
	localparam logic [2:0] MODE_CONST  = 3'd0;
	localparam logic [2:0] MODE_LINEAR = 3'd1;
	localparam logic [2:0] MODE_EXP    = 3'd2;
	localparam logic [2:0] MODE_EXP2   = 3'd3;

	// register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_COLOR  = 3'd1;
	localparam logic [2:0] REG_NEAR   = 3'd2;
	localparam logic [2:0] REG_FAR    = 3'd3;
	localparam logic [2:0] REG_FIRST  = 3'd4;
	localparam logic [2:0] REG_SECOND = 3'd5;

	// pipeline layout
	localparam int ST_DIV0  = 4;
	localparam int DIV_STEPS = 17;
	localparam int ST_EXP0  = 7;
	localparam int EXP_BITS = 16;
	localparam int ST_LAST  = ST_EXP0 + EXP_BITS;
	localparam int NS       = ST_LAST + 1;

	// 2^(-2^-k) in q0.16, k = 1..16
	localparam logic [15:0] POW2_NEG [EXP_BITS] = '{
		16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830, 16'd65182,
		16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525, 16'd65530, 16'd65533,
		16'd65535, 16'd65535
	};

	typedef logic [D_W-1:0] dtab_t [2**IDX_W];

	// normalized depth per entry, index saturated to the last entry
	function automatic dtab_t build_dtab();
		dtab_t  tab;
		longint ii;
		for (int i = 0; i < 2**IDX_W; i++) begin
			ii = (i > LAST) ? longint'(LAST) : longint'(i);
			tab[i] = D_W'((ii * 65536 + LAST / 2) / LAST);
		end
		return tab;
	endfunction

	localparam dtab_t D_TAB = build_dtab();

endpackage

`default_nettype wire

// ===== rtl/core/fog_table_entry_generator.sv =====
// fog table entry generator: index in, rgba entry out, fully pipelined
// depends on fte_pkg and fog_table_entry_generator_defines.svh
//
// channel   | dir | fields
// s_axis    | in  | tdata[7:0] entry_index
// m_axis    | out | tdata entry_number, red, green, blue, alpha (low to high)
// cfg       | in  | cfg_we, cfg_index, cfg_data (plain register writes)
//
// one entry per cycle while m_axis does not stall; the 17 stage divider
// for linear fog and the 16 stage multiply chain for the exp modes are pipelined.
// arst_n clears the valid bits and the config registers to their reset values.
// a stall on m_axis freezes every stage; s_axis_tready drops with it.
`timescale 1ns / 1ps
`default_nettype none
`include "fog_table_entry_generator_defines.svh"

module fog_table_entry_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] entry_index
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // entry_number, red, green, blue, alpha
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import fte_pkg::*;

	logic [2:0]         fog_mode_q;
	logic [31:0]        fog_color_q;
	logic [31:0]        near_q;
	logic [31:0]        far_q;
	logic signed [31:0] pf_q;
	logic signed [31:0] ps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_mode_q  <= MODE_CONST;
			fog_color_q <= '0;
			near_q      <= 32'd65536;
			far_q       <= 32'd65536000;
			pf_q        <= 32'sd65536;
			ps_q        <= 32'sd6553600;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   fog_mode_q  <= cfg_data[2:0];
				REG_COLOR:  fog_color_q <= cfg_data;
				REG_NEAR:   near_q      <= cfg_data;
				REG_FAR:    far_q       <= cfg_data;
				REG_FIRST:  pf_q        <= cfg_data;
				REG_SECOND: ps_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// terms that depend on configuration only
	logic signed [32:0] span_raw;
	logic signed [32:0] den_raw;
	logic [31:0]        span;
	logic [31:0]        den;
	logic [31:0]        mag;
	logic               mode_exp2;

	assign mode_exp2 = (fog_mode_q == MODE_EXP2);
	assign span_raw  = $signed({1'b0, far_q}) - $signed({1'b0, near_q});
	assign den_raw   = $signed({ps_q[31], ps_q}) - $signed({pf_q[31], pf_q});
	assign span      = (span_raw < $signed({1'b0, MIN_SPAN})) ? MIN_SPAN : span_raw[31:0];
	assign den       = (den_raw < $signed({1'b0, MIN_SPAN})) ? MIN_SPAN : den_raw[31:0];
	assign mag       = (mode_exp2 && pf_q[31]) ? 32'(-pf_q) : pf_q;

	// pipeline control
	logic [NS:1] vld_q;
	logic        pipe_en;

	assign pipe_en       = !vld_q[NS] || m_axis_tready;
	assign s_axis_tready = pipe_en;
	assign m_axis_tvalid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[NS-1:1], s_axis_tvalid};
		end
	end

	logic [7:0] idx_s [1:ST_LAST];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			idx_s[1] <= s_axis_tdata[7:0];
			for (int k = 2; k <= ST_LAST; k++) begin
				idx_s[k] <= idx_s[k-1];
			end
		end
	end

	// front stages: depth, products, view depth and exponent
	logic [D_W-1:0] d_s1;
	logic [48:0]    prodl_s2;
	logic [48:0]    prode_s2;
	logic [32:0]    num_s3;
	logic [31:0]    y_s3;
	logic           big_s4;
	logic [37:0]    sq_s4;
	logic [31:0]    xr_s4;
	logic [20:0]    x_s5;
	logic           huge_s5;
	logic [21:0]    t_s6;
	logic           huge_s6;

	logic [48:0]        rl_c;
	logic signed [34:0] z_c;
	logic signed [34:0] pfe_c;
	logic signed [34:0] pse_c;
	logic signed [34:0] c_c;
	logic signed [34:0] num_c;
	logic [48:0]        re_c;
	logic [37:0]        x_c;
	logic [37:0]        tp_c;

	always_comb begin
		rl_c  = (prodl_s2 + 49'd32768) >> 16;
		z_c   = $signed({3'b000, near_q}) + $signed({2'b00, rl_c[32:0]});
		pfe_c = 35'(pf_q);
		pse_c = 35'(ps_q);
		c_c   = (z_c < pfe_c) ? pfe_c : z_c;
		c_c   = (c_c > pse_c) ? pse_c : c_c;
		num_c = pse_c - c_c;
		re_c  = (prode_s2 + 49'd32768) >> 16;
		x_c   = mode_exp2 ? ((sq_s4 + 38'd32768) >> 16) : {6'd0, xr_s4};
		tp_c  = (38'(x_s5) * 38'(LOG2E_Q16) + 38'd32768) >> 16;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			d_s1     <= D_TAB[s_axis_tdata[7:0]];
			prodl_s2 <= 49'(d_s1) * 49'(span);
			prode_s2 <= 49'(d_s1) * 49'(mag);
			num_s3   <= num_c[32:0];
			y_s3     <= re_c[31:0];
			big_s4   <= |y_s3[31:19];
			sq_s4    <= 38'(y_s3[18:0]) * 38'(y_s3[18:0]);
			xr_s4    <= y_s3;
			x_s5     <= x_c[20:0];
			huge_s5  <= (mode_exp2 && big_s4) || (x_c >= X_LIMIT);
			t_s6     <= tp_c[21:0];
			huge_s6  <= huge_s5;
		end
	end

	// linear fog: restoring divider, one quotient bit per stage
	logic [32:0]      rem_s [ST_DIV0:ST_DIV0+DIV_STEPS-1];
	logic [FIX_W-1:0] q_s   [ST_DIV0:ST_LAST];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [33:0]      r_in;
		logic [FIX_W-1:0] q_in;
		logic             ge;
		if (k == 0) begin : g_first
			assign r_in = {1'b0, num_s3};
			assign q_in = '0;
		end else begin : g_next
			assign r_in = {rem_s[ST_DIV0+k-1], 1'b0};
			assign q_in = q_s[ST_DIV0+k-1];
		end
		assign ge = (r_in >= {2'b00, den});
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rem_s[ST_DIV0+k] <= ge ? 33'(r_in - {2'b00, den}) : r_in[32:0];
				q_s[ST_DIV0+k]   <= {q_in[FIX_W-2:0], ge};
			end
		end
	end

	for (genvar k = ST_DIV0 + DIV_STEPS; k <= ST_LAST; k++) begin : g_qdly
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				q_s[k] <= q_s[k-1];
			end
		end
	end

	// exp modes: one constant multiply per set fraction bit of t
	logic [FIX_W-1:0] p_s    [ST_EXP0:ST_LAST];
	logic [15:0]      f_s    [ST_EXP0:ST_LAST];
	logic [4:0]       n_s    [ST_EXP0:ST_LAST];
	logic             zero_s [ST_EXP0:ST_LAST];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			p_s[ST_EXP0]    <= FIX_ONE;
			f_s[ST_EXP0]    <= t_s6[15:0];
			n_s[ST_EXP0]    <= t_s6[20:16];
			zero_s[ST_EXP0] <= huge_s6 || (t_s6[21:16] >= 6'd17);
		end
	end

	for (genvar b = 0; b < EXP_BITS; b++) begin : g_exp
		localparam int ST = ST_EXP0 + 1 + b;
		logic [32:0] prod;
		assign prod = (33'(p_s[ST-1]) * 33'(POW2_NEG[b]) + 33'd32768) >> 16;
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				p_s[ST]    <= f_s[ST-1][EXP_BITS-1-b] ? prod[FIX_W-1:0] : p_s[ST-1];
				f_s[ST]    <= f_s[ST-1];
				n_s[ST]    <= n_s[ST-1];
				zero_s[ST] <= zero_s[ST-1];
			end
		end
	end

	// final stage: falloff select, alpha, output register
	logic [17:0]      sh_c;
	logic [17:0]      rnd_c;
	logic [FIX_W-1:0] fexp_c;
	logic [FIX_W-1:0] fall_c;
	logic [FIX_W-1:0] inv_c;
	logic [7:0]       alpha_c;

	always_comb begin
		sh_c   = {p_s[ST_LAST], 1'b0} >> n_s[ST_LAST];
		rnd_c  = (sh_c + 18'd1) >> 1;
		if (zero_s[ST_LAST]) begin
			fexp_c = '0;
		end else if (rnd_c > 18'(FIX_ONE)) begin
			fexp_c = FIX_ONE;
		end else begin
			fexp_c = rnd_c[FIX_W-1:0];
		end
		case (fog_mode_q)
			MODE_LINEAR: fall_c = (q_s[ST_LAST] > FIX_ONE) ? FIX_ONE : q_s[ST_LAST];
			MODE_EXP:    fall_c = pf_q[31] || (pf_q == 32'sd0) ? FIX_ONE : fexp_c;
			MODE_EXP2:   fall_c = fexp_c;
			default:     fall_c = FIX_ONE;
		endcase
		inv_c = FIX_ONE - fall_c;
		if (fog_mode_q == MODE_CONST) begin
			alpha_c = fog_color_q[31:24];
		end else if (idx_s[ST_LAST] == 8'd0) begin
			alpha_c = 8'd0;
		end else begin
			alpha_c = inv_c[16:9];
		end
	end

	logic [39:0] data_s24;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			data_s24 <= {alpha_c, fog_color_q[23:0], idx_s[ST_LAST]};
		end
	end

	assign m_axis_tdata = data_s24;

	`FTE_ASSERT_NOW(a_exp_bound, vld_q[ST_LAST], p_s[ST_LAST] <= FIX_ONE, "exp product above one")
	`FTE_ASSERT_NEXT(a_stall_freeze, !pipe_en, $stable(vld_q), "pipeline moved during stall")

endmodule

`default_nettype wire
